[rtl/core/dsrm_pkg.sv]
// ----------------------------------------------------------------------------
// dsrm_pkg
// shared types and constants for the disjoint-set range merge block
// ----------------------------------------------------------------------------
package dsrm_pkg;

    localparam int FIELD_W = 11;

    typedef enum logic [1:0] {
        KIND_UNION = 2'd0,
        KIND_RANGE = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

endpackage

[rtl/core/disjoint_set_range_merge.sv]
// ----------------------------------------------------------------------------
// disjoint_set_range_merge
// union-find store with union, range merge and same-set query
// ----------------------------------------------------------------------------
// channel | dir | fields (low bit first)                         | tuser
// s_axis  | in  | tdata: kind[1:0], node_a[12:2], node_b[23:13]  | -
// m_axis  | out | tdata: same_set[0]                             | -
// cfg     | in  | cfg_wdata: node_count[10:0]                    | -
// a clearing pass over all MAX_NODES+1 entries follows reset; s_axis_tready stays low then
// a find reads and checks each node on the walk to the root, reads and checks each
//   node again on the compression pass, then dispatches
// a query is two finds plus a load of the output register; a union is two finds
//   plus a size compare and a link
// a range merge is a run-end find plus a run-end read and check, then per run crossed
//   a run join (two run finds, link, run-end merge), a union and another run-end find
// s_axis_tready is high only in idle; a finished query waits for the previous transfer
// ----------------------------------------------------------------------------
module disjoint_set_range_merge #(
    parameter int MAX_NODES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // kind, node_a, node_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // same_set
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata       // node_count
);

    localparam int FW = dsrm_pkg::FIELD_W;
    localparam int DEPTH = MAX_NODES + 1;
    localparam int NW = $clog2(DEPTH);  // node indices and set sizes

    typedef enum logic [16:0] {
        S_CLEAR  = 17'd1 << 0,
        S_IDLE   = 17'd1 << 1,
        S_FRD    = 17'd1 << 2,   // read parent of cursor
        S_FCHK   = 17'd1 << 3,   // compare parent with cursor
        S_CRD    = 17'd1 << 4,   // compression read
        S_CCHK   = 17'd1 << 5,
        S_DISP   = 17'd1 << 6,   // after a find returns
        S_SZRD   = 17'd1 << 7,
        S_SZA    = 17'd1 << 8,
        S_SZB    = 17'd1 << 9,
        S_SZW    = 17'd1 << 10,
        S_LRD    = 17'd1 << 11,  // run end merge after a run link
        S_LA     = 17'd1 << 12,
        S_LB     = 17'd1 << 13,
        S_XRD    = 17'd1 << 14,  // read run end of run root
        S_XCHK   = 17'd1 << 15,
        S_OUT    = 17'd1 << 16
    } state_t;

    // find purposes
    typedef enum logic [2:0] {
        P_QA = 3'd0,
        P_QB = 3'd1,
        P_JA = 3'd2,
        P_JB = 3'd3,
        P_RL = 3'd4
    } purp_t;

    state_t state_reg, state_next, join_next;
    purp_t  purp_reg;
    logic   frun_reg;          // find works on run forest
    logic   jmode_reg;         // join is part of a range merge
    logic [NW-1:0] clr_reg;
    logic [NW-1:0] cur_reg, start_reg, root_reg, ra_reg, rb_reg, sa_reg, sb_reg;
    logic [NW-1:0] a_reg, b_reg, hi_reg, lasta_reg;
    logic [FW-1:0] cnt_reg;
    logic          res_reg, ovld_reg;

    // memories: set parent, set size, run parent, run size, run last
    logic          sp_we, ss_we, rp_we, rs_we, rl_we;
    logic [NW-1:0] sp_wa, ss_wa, rp_wa, rs_wa, rl_wa;
    logic [NW-1:0] sp_wd, ss_wd, rp_wd, rs_wd, rl_wd;
    logic [NW-1:0] sp_ra, ss_ra, rp_ra, rs_ra, rl_ra;
    logic [NW-1:0] sp_rd, ss_rd, rp_rd, rs_rd, rl_rd;

    dsrm_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_sp (.clk, .we(sp_we), .waddr(sp_wa),
        .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_rd));
    dsrm_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_ss (.clk, .we(ss_we), .waddr(ss_wa),
        .wdata(ss_wd), .raddr(ss_ra), .rdata(ss_rd));
    dsrm_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_rp (.clk, .we(rp_we), .waddr(rp_wa),
        .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd));
    dsrm_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_rs (.clk, .we(rs_we), .waddr(rs_wa),
        .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
    dsrm_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_rl (.clk, .we(rl_we), .waddr(rl_wa),
        .wdata(rl_wd), .raddr(rl_ra), .rdata(rl_rd));

    logic [NW-1:0]    par_rd, sz_rd, sz_sum;
    logic [FW-1:0]    in_a, in_b, lim;
    dsrm_pkg::kind_t  in_kind;
    logic             in_ok;
    logic [NW:0]      xp1;
    logic             run_more;
    logic             join_end;

    assign par_rd  = frun_reg ? rp_rd : sp_rd;
    assign sz_rd   = frun_reg ? rs_rd : ss_rd;
    assign sz_sum  = sa_reg + sb_reg;
    assign in_kind = dsrm_pkg::kind_t'(s_axis_tdata[1:0]);
    assign in_a    = s_axis_tdata[12:2];
    assign in_b    = s_axis_tdata[23:13];
    assign lim = ({{(32-FW){1'b0}}, cnt_reg} > 32'(MAX_NODES)) ? FW'(MAX_NODES) : cnt_reg;
    assign in_ok = (in_a != '0) && (in_b != '0) && (in_a <= lim) && (in_b <= lim) &&
                   (in_kind != dsrm_pkg::KIND_RSVD);
    // next node after the end of the current run
    assign xp1      = {1'b0, rl_rd} + (NW+1)'(1);
    assign run_more = (xp1 <= {1'b0, hi_reg});

    // a join on one forest is finished
    assign join_end = ((state_reg == S_DISP) && (purp_reg == P_JB) && (root_reg == ra_reg)) ||
                      ((state_reg == S_SZW) && !frun_reg) || (state_reg == S_LB);
    assign join_next = (frun_reg || jmode_reg) ? S_FRD : S_IDLE;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {7'd0, res_reg};

    // memory port control
    always_comb
    begin
        sp_we = 1'b0; ss_we = 1'b0; rp_we = 1'b0; rs_we = 1'b0; rl_we = 1'b0;
        sp_wa = cur_reg; rp_wa = cur_reg;
        ss_wa = ra_reg; rs_wa = ra_reg; rl_wa = ra_reg;
        sp_wd = root_reg; rp_wd = root_reg;
        ss_wd = sz_sum; rs_wd = sz_sum; rl_wd = rl_rd;
        sp_ra = cur_reg; rp_ra = cur_reg;
        ss_ra = ra_reg; rs_ra = ra_reg; rl_ra = ra_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                sp_we = 1'b1; ss_we = 1'b1; rp_we = 1'b1; rs_we = 1'b1; rl_we = 1'b1;
                sp_wa = clr_reg; ss_wa = clr_reg; rp_wa = clr_reg;
                rs_wa = clr_reg; rl_wa = clr_reg;
                sp_wd = clr_reg; rp_wd = clr_reg; rl_wd = clr_reg;
                ss_wd = NW'(1); rs_wd = NW'(1);
            end
            S_CCHK:
            begin
                // compress one link: parent(cur) := root
                if (par_rd != root_reg)
                begin
                    sp_we = !frun_reg;
                    rp_we = frun_reg;
                end
            end
            S_SZA:
            begin
                ss_ra = rb_reg; rs_ra = rb_reg;
            end
            S_SZW:
            begin
                if (frun_reg)
                begin
                    rp_we = 1'b1; rp_wa = rb_reg; rp_wd = ra_reg;
                    rs_we = 1'b1;
                end
                else
                begin
                    sp_we = 1'b1; sp_wa = rb_reg; sp_wd = ra_reg;
                    ss_we = 1'b1;
                end
            end
            S_LA:
            begin
                rl_ra = rb_reg;
            end
            S_LB:
            begin
                rl_we = (rl_rd > lasta_reg);
            end
            S_XRD:
            begin
                rl_ra = root_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= FW'(1024);
            ovld_reg  <= 1'b0;
            res_reg   <= 1'b0;
            purp_reg  <= P_QA;
            frun_reg  <= 1'b0;
            jmode_reg <= 1'b0;
            cur_reg   <= '0;
            start_reg <= '0;
            root_reg  <= '0;
            ra_reg    <= '0;
            rb_reg    <= '0;
            sa_reg    <= '0;
            sb_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            hi_reg    <= '0;
            lasta_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cnt_reg <= cfg_wdata;
            end
            if ((state_reg == S_OUT) && (!ovld_reg || m_axis_tready))
            begin
                res_reg  <= (ra_reg == rb_reg);
                ovld_reg <= 1'b1;
            end
            else if (ovld_reg && m_axis_tready)
            begin
                ovld_reg <= 1'b0;
            end
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + NW'(1);
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && in_ok)
                    begin
                        a_reg     <= NW'(in_a);
                        b_reg     <= NW'(in_b);
                        hi_reg    <= NW'(in_b);
                        cur_reg   <= NW'(in_a);
                        start_reg <= NW'(in_a);
                        jmode_reg <= (in_kind == dsrm_pkg::KIND_RANGE);
                        if (in_kind == dsrm_pkg::KIND_RANGE)
                        begin
                            frun_reg <= 1'b1;
                            purp_reg <= P_RL;
                        end
                        else
                        begin
                            frun_reg <= 1'b0;
                            purp_reg <= (in_kind == dsrm_pkg::KIND_QUERY) ? P_QA : P_JA;
                        end
                    end
                end
                S_FCHK:
                begin
                    if (par_rd == cur_reg)
                    begin
                        root_reg <= cur_reg;
                        cur_reg  <= start_reg;
                    end
                    else
                    begin
                        cur_reg <= par_rd;
                    end
                end
                S_CCHK:
                begin
                    cur_reg <= par_rd;
                end
                S_DISP:
                begin
                    unique case (purp_reg)
                        P_QA, P_JA:
                        begin
                            ra_reg <= root_reg; cur_reg <= b_reg; start_reg <= b_reg;
                            purp_reg <= (purp_reg == P_QA) ? P_QB : P_JB;
                        end
                        P_QB, P_JB:
                        begin
                            rb_reg <= root_reg;
                        end
                        default: ;
                    endcase
                end
                S_SZA:
                begin
                    sa_reg <= sz_rd;
                end
                S_SZB:
                begin
                    if (sz_rd > sa_reg)
                    begin
                        // larger set stays root; ties keep the first root
                        ra_reg <= rb_reg; rb_reg <= ra_reg;
                        sa_reg <= sz_rd;  sb_reg <= sa_reg;
                    end
                    else
                    begin
                        sb_reg <= sz_rd;
                    end
                end
                S_LA:
                begin
                    lasta_reg <= rl_rd;
                end
                S_XCHK:
                begin
                    if (run_more)
                    begin
                        // join the run ending at x with the one starting at x+1
                        a_reg <= rl_rd; b_reg <= xp1[NW-1:0];
                        cur_reg <= rl_rd; start_reg <= rl_rd;
                        frun_reg <= 1'b1; purp_reg <= P_JA;
                    end
                end
                default: ;
            endcase
            if (join_end)
            begin
                cur_reg   <= a_reg;
                start_reg <= a_reg;
                if (frun_reg)
                begin
                    // run part done, now the set union of the same pair
                    frun_reg <= 1'b0;
                    purp_reg <= P_JA;
                end
                else if (jmode_reg)
                begin
                    frun_reg <= 1'b1;
                    purp_reg <= P_RL;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: state_next = (clr_reg == NW'(MAX_NODES)) ? S_IDLE : S_CLEAR;
            S_IDLE:
            begin
                if (s_axis_tvalid && in_ok)
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:  state_next = S_FCHK;
            S_FCHK: state_next = (par_rd == cur_reg) ? S_CRD : S_FRD;
            S_CRD:  state_next = S_CCHK;
            S_CCHK: state_next = (par_rd == root_reg) ? S_DISP : S_CRD;
            S_DISP:
            begin
                unique case (purp_reg)
                    P_QB:    state_next = S_OUT;
                    P_JB:    state_next = (root_reg == ra_reg) ? join_next : S_SZRD;
                    P_RL:    state_next = S_XRD;
                    default: state_next = S_FRD;
                endcase
            end
            S_SZRD: state_next = S_SZA;
            S_SZA:  state_next = S_SZB;
            S_SZB:  state_next = S_SZW;
            S_SZW:  state_next = frun_reg ? S_LRD : join_next;
            S_LRD:  state_next = S_LA;
            S_LA:   state_next = S_LB;
            S_LB:   state_next = join_next;
            S_XRD:  state_next = S_XCHK;
            S_XCHK: state_next = run_more ? S_FRD : S_IDLE;
            S_OUT:  state_next = (!ovld_reg || m_axis_tready) ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)));

    a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRD) |-> ((cur_reg != '0) && (cur_reg <= NW'(MAX_NODES))));

endmodule

[rtl/core/dsrm_ram.sv]
// ----------------------------------------------------------------------------
// dsrm_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module dsrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
